>>> hdl/gapf_pkg.sv
// Shared types, codes and default sizes for the articulation point finder.
`default_nettype none
package gapf_pkg;

  localparam int DEF_MAX_NODES = 1024;
  localparam int DEF_MAX_SLOTS = 8192;
  localparam int NODE_W        = 10;
  localparam int CFG_W         = 11;
  localparam int OP_W          = 2;
  localparam int STATUS_W      = 2;

  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_RUN   = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  // Command as classified by the front end.
  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [NODE_W-1:0]   a;
    logic [NODE_W-1:0]   b;
    logic [STATUS_W-1:0] status;
  } cmd_t;

endpackage
`default_nettype wire

>>> hdl/gapf_front.sv
// Front end: range check of edge and query commands and a two-entry command queue.
`default_nettype none
module gapf_front
  import gapf_pkg::*;
#(
  parameter int MAX_NODES = DEF_MAX_NODES
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [OP_W-1:0]                  in_op,
  input  wire logic [NODE_W-1:0]                in_a,
  input  wire logic [NODE_W-1:0]                in_b,
  input  wire logic [$clog2(MAX_NODES+1)-1:0]   n_eff,
  input  wire logic                             enable,
  output logic                                  cmd_valid,
  output cmd_t                                  cmd,
  input  wire logic                             cmd_pop
);

  localparam int CNTW = $clog2(MAX_NODES + 1);
  localparam int KW   = (CNTW > CFG_W) ? CNTW : CFG_W;

  cmd_t       q [2];
  logic [1:0] count;
  cmd_t       c_in;
  logic       a_bad, b_bad, push, to_head;

  always_comb begin
    a_bad = KW'(in_a) >= KW'(n_eff);
    b_bad = KW'(in_b) >= KW'(n_eff);
    c_in.op = in_op;
    c_in.a = in_a;
    c_in.b = in_b;
    c_in.status = ST_OK;
    case (in_op)
      OP_ADD:   if (a_bad || b_bad) c_in.status = ST_RANGE;
      OP_QUERY: if (a_bad) c_in.status = ST_RANGE;
      default:  c_in.status = ST_OK;
    endcase
  end

  assign in_ready  = enable && (count != 2'd2);
  assign push      = in_valid && in_ready;
  assign cmd_valid = count != 2'd0;
  assign cmd       = q[0];
  // A new command lands at the head when the queue is empty after this cycle's pop.
  assign to_head   = push && ((count == 2'd0) || (cmd_pop && (count == 2'd1)));

  always_ff @(posedge clk) begin
    if (to_head) begin
      q[0] <= c_in;
    end else if (cmd_pop) begin
      q[0] <= q[1];
    end
    if (push && !to_head) begin
      q[1] <= c_in;
    end
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + 2'(push) - 2'(cmd_pop);
    end
  end

endmodule
`default_nettype wire

>>> hdl/gapf_engine.sv
// Back end: adjacency storage, depth-first cut vertex search and queries.
`default_nettype none
module gapf_engine
  import gapf_pkg::*;
#(
  parameter int MAX_NODES = DEF_MAX_NODES,
  parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [$clog2(MAX_NODES+1)-1:0] n_eff,
  input  wire logic                           cmd_valid,
  input  wire cmd_t                           cmd,
  output logic                                cmd_pop,
  output logic                                ready_init,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_flag,
  output logic [STATUS_W-1:0]                 out_status
);

  localparam int NW     = $clog2(MAX_NODES);
  localparam int CNTW   = $clog2(MAX_NODES + 1);
  localparam int SW     = $clog2(MAX_SLOTS);
  localparam int SCW    = $clog2(MAX_SLOTS + 1);
  localparam int AW     = (SW + 1 > NW) ? SW + 1 : NW;
  localparam int DEPTH  = 2 * MAX_NODES + 2;
  localparam int KAW    = $clog2(DEPTH);
  localparam int STCW   = $clog2(DEPTH + 1);

  typedef struct packed {
    logic          none;
    logic [SW-1:0] idx;
  } link_t;

  typedef struct packed {
    logic          empty;
    logic [SW-1:0] head;
    logic [SW-1:0] tail;
  } head_t;

  typedef struct packed {
    logic [CNTW-1:0] disc;
    logic [CNTW-1:0] low;
    logic            par_none;
    logic [NW-1:0]   par;
    logic [1:0]      child;
    logic            cut;
  } info_t;

  typedef struct packed {
    logic [NW-1:0] node;
    logic          post;
    logic [AW-1:0] arg;
  } entry_t;

  typedef enum logic [18:0] {
    S_INIT      = 19'h00001,
    S_IDLE      = 19'h00002,
    S_ADD_RD    = 19'h00004,
    S_ADD_LINK  = 19'h00008,
    S_ADD_TAIL  = 19'h00010,
    S_ADD_NEXT  = 19'h00020,
    S_QUERY     = 19'h00040,
    S_CLR       = 19'h00080,
    S_ROOT_RD   = 19'h00100,
    S_ROOT_CHK  = 19'h00200,
    S_ROOT_PUSH = 19'h00400,
    S_POP       = 19'h00800,
    S_POP_GOT   = 19'h01000,
    S_U_CHK     = 19'h02000,
    S_SLOT_CHK  = 19'h04000,
    S_V_CHK     = 19'h08000,
    S_VH_RD     = 19'h10000,
    S_VH_PUSH   = 19'h20000,
    S_PV_CHK    = 19'h40000
  } state_t;

  localparam info_t INFO_CLEAR = '{disc: '0, low: '0, par_none: 1'b1, par: '0,
                                   child: '0, cut: 1'b0};
  localparam head_t HEAD_EMPTY = '{empty: 1'b1, head: '0, tail: '0};
  localparam link_t LINK_NONE  = '{none: 1'b1, idx: '0};

  // Storage.
  head_t          head_mem [MAX_NODES];
  logic [NW-1:0]  nbr_mem  [MAX_SLOTS];
  link_t          next_mem [MAX_SLOTS];
  info_t          info_mem [MAX_NODES];
  entry_t         stk_mem  [DEPTH];

  logic head_we, nbr_we, next_we, info_we, stk_we;
  logic [NW-1:0]  head_wa, head_ra, info_wa, info_ra;
  logic [SW-1:0]  nbr_wa, next_wa, slot_ra;
  logic [KAW-1:0] stk_wa, stk_ra;
  head_t  head_wd, head_rd;
  logic [NW-1:0] nbr_wd, nbr_rd;
  link_t  next_wd, next_rd;
  info_t  info_wd, info_rd;
  entry_t stk_wd, stk_rd;

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_rd <= head_mem[head_ra];
  end
  always_ff @(posedge clk) begin
    if (nbr_we) nbr_mem[nbr_wa] <= nbr_wd;
    nbr_rd <= nbr_mem[slot_ra];
  end
  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    next_rd <= next_mem[slot_ra];
  end
  always_ff @(posedge clk) begin
    if (info_we) info_mem[info_wa] <= info_wd;
    info_rd <= info_mem[info_ra];
  end
  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    stk_rd <= stk_mem[stk_ra];
  end

  // Control registers.
  state_t state, state_next;
  logic [NW-1:0]   idx, idx_next;
  logic [CNTW-1:0] root, root_next;
  logic [CNTW-1:0] tcnt, tcnt_next;
  logic [STCW-1:0] top, top_next;
  logic [SCW-1:0]  slots_used, slots_used_next;
  logic [NW-1:0]   own, own_next, nb, nb_next;
  logic            pass, pass_next;
  logic [SW-1:0]   tl, tl_next;
  logic [NW-1:0]   u, u_next, v, v_next;
  logic            epost, epost_next;
  logic [AW-1:0]   earg, earg_next;
  info_t           uinf, uinf_next;
  logic            ov_set, ov_flag, ov_full;
  logic [STATUS_W-1:0] ov_status;

  info_t  ucur, vinf;
  logic   push;
  entry_t push_e;
  logic   idx_last;
  logic [NW-1:0] root_idx;

  assign idx_last   = idx == NW'(MAX_NODES - 1);
  assign root_idx   = root[NW-1:0];
  assign ready_init = state != S_INIT;
  assign ov_full    = (SCW + 1)'(slots_used) + (SCW + 1)'(2) > (SCW + 1)'(MAX_SLOTS);

  always_comb begin
    state_next = state;
    idx_next = idx;
    root_next = root;
    tcnt_next = tcnt;
    top_next = top;
    slots_used_next = slots_used;
    own_next = own;
    nb_next = nb;
    pass_next = pass;
    tl_next = tl;
    u_next = u;
    v_next = v;
    epost_next = epost;
    earg_next = earg;
    uinf_next = uinf;
    ov_set = 1'b0;
    ov_flag = 1'b0;
    ov_status = ST_OK;
    cmd_pop = 1'b0;

    head_we = 1'b0; head_wa = idx; head_wd = HEAD_EMPTY; head_ra = own;
    nbr_we = 1'b0; nbr_wa = slots_used[SW-1:0]; nbr_wd = nb;
    next_we = 1'b0; next_wa = slots_used[SW-1:0]; next_wd = LINK_NONE;
    slot_ra = earg[SW-1:0];
    info_we = 1'b0; info_wa = u; info_wd = uinf; info_ra = u;
    stk_ra = KAW'(top - STCW'(1));
    push = 1'b0;
    push_e = '{node: u, post: 1'b0, arg: '0};

    ucur = info_rd;
    vinf = (v == u) ? uinf : info_rd;

    case (state)
      S_INIT: begin
        head_we = 1'b1;
        info_we = 1'b1; info_wa = idx; info_wd = INFO_CLEAR;
        idx_next = idx + NW'(1);
        if (idx_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (cmd_valid && !out_valid) begin
          cmd_pop = 1'b1;
          own_next = NW'(cmd.a);
          nb_next = NW'(cmd.b);
          pass_next = 1'b0;
          info_ra = NW'(cmd.a);
          if (cmd.status != ST_OK) begin
            ov_set = 1'b1; ov_status = cmd.status;
          end else begin
            case (cmd.op)
              OP_ADD: begin
                if (ov_full) begin
                  ov_set = 1'b1; ov_status = ST_FULL;
                end else begin
                  state_next = S_ADD_RD;
                end
              end
              OP_RUN: begin
                idx_next = '0;
                state_next = S_CLR;
              end
              OP_QUERY: state_next = S_QUERY;
              default: ov_set = 1'b1;
            endcase
          end
        end
      end
      S_ADD_RD: begin
        head_ra = own;
        state_next = S_ADD_LINK;
      end
      S_ADD_LINK: begin
        nbr_we = 1'b1;
        next_we = 1'b1;
        head_we = 1'b1; head_wa = own;
        head_wd.empty = 1'b0;
        head_wd.tail = slots_used[SW-1:0];
        head_wd.head = head_rd.empty ? slots_used[SW-1:0] : head_rd.head;
        tl_next = head_rd.tail;
        state_next = head_rd.empty ? S_ADD_NEXT : S_ADD_TAIL;
      end
      S_ADD_TAIL: begin
        next_we = 1'b1; next_wa = tl;
        next_wd = '{none: 1'b0, idx: slots_used[SW-1:0]};
        state_next = S_ADD_NEXT;
      end
      S_ADD_NEXT: begin
        slots_used_next = slots_used + SCW'(1);
        if (!pass) begin
          pass_next = 1'b1;
          own_next = nb;
          nb_next = own;
          state_next = S_ADD_RD;
        end else begin
          ov_set = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_QUERY: begin
        ov_set = 1'b1; ov_flag = info_rd.cut;
        state_next = S_IDLE;
      end
      S_CLR: begin
        info_we = 1'b1; info_wa = idx; info_wd = INFO_CLEAR;
        idx_next = idx + NW'(1);
        if (idx_last) begin
          root_next = '0; tcnt_next = '0; top_next = '0;
          state_next = S_ROOT_RD;
        end
      end
      S_ROOT_RD: begin
        if (root >= n_eff) begin
          ov_set = 1'b1;
          state_next = S_IDLE;
        end else begin
          info_ra = root_idx;
          state_next = S_ROOT_CHK;
        end
      end
      S_ROOT_CHK: begin
        if (info_rd.disc != '0) begin
          root_next = root + CNTW'(1);
          state_next = S_ROOT_RD;
        end else begin
          head_ra = root_idx;
          state_next = S_ROOT_PUSH;
        end
      end
      S_ROOT_PUSH: begin
        push = 1'b1;
        push_e.node = root_idx;
        push_e.arg = head_rd.empty ? AW'(LINK_NONE) : AW'({1'b0, head_rd.head});
        state_next = S_POP;
      end
      S_POP: begin
        if (top == '0) begin
          root_next = root + CNTW'(1);
          state_next = S_ROOT_RD;
        end else begin
          top_next = top - STCW'(1);
          state_next = S_POP_GOT;
        end
      end
      S_POP_GOT: begin
        u_next = stk_rd.node;
        epost_next = stk_rd.post;
        earg_next = stk_rd.arg;
        info_ra = stk_rd.node;
        state_next = S_U_CHK;
      end
      S_U_CHK: begin
        if (epost) begin
          uinf_next = info_rd;
          info_ra = earg[NW-1:0];
          state_next = S_PV_CHK;
        end else begin
          if (info_rd.disc == '0) begin
            tcnt_next = tcnt + CNTW'(1);
            ucur.disc = tcnt + CNTW'(1);
            ucur.low = tcnt + CNTW'(1);
          end
          uinf_next = ucur;
          if (earg[SW]) begin
            info_we = 1'b1; info_wd = ucur;
            state_next = S_POP;
          end else begin
            slot_ra = earg[SW-1:0];
            state_next = S_SLOT_CHK;
          end
        end
      end
      S_SLOT_CHK: begin
        v_next = nbr_rd;
        if (!next_rd.none) begin
          push = 1'b1;
          push_e.arg = AW'(next_rd);
        end
        if (CNTW'(nbr_rd) >= n_eff) begin
          info_we = 1'b1;
          state_next = S_POP;
        end else begin
          info_ra = nbr_rd;
          state_next = S_V_CHK;
        end
      end
      S_V_CHK: begin
        if (vinf.disc == '0) begin
          if (uinf.child != 2'd2) uinf_next.child = uinf.child + 2'd1;
          info_we = 1'b1; info_wa = v;
          info_wd = vinf;
          info_wd.par_none = 1'b0;
          info_wd.par = u;
          push = 1'b1;
          push_e.post = 1'b1;
          push_e.arg = AW'(v);
          state_next = S_VH_RD;
        end else begin
          if ((uinf.par_none || uinf.par != v) && vinf.disc < uinf.low) begin
            uinf_next.low = vinf.disc;
          end
          info_we = 1'b1; info_wd = uinf_next;
          state_next = S_POP;
        end
      end
      S_VH_RD: begin
        info_we = 1'b1;
        head_ra = v;
        state_next = S_VH_PUSH;
      end
      S_VH_PUSH: begin
        push = 1'b1;
        push_e.node = v;
        push_e.arg = head_rd.empty ? AW'(LINK_NONE) : AW'({1'b0, head_rd.head});
        state_next = S_POP;
      end
      S_PV_CHK: begin
        if (info_rd.low < uinf.low) uinf_next.low = info_rd.low;
        if (uinf.par_none && uinf.child > 2'd1) uinf_next.cut = 1'b1;
        if (!uinf.par_none && info_rd.low >= uinf.disc) uinf_next.cut = 1'b1;
        info_we = 1'b1; info_wd = uinf_next;
        state_next = S_POP;
      end
      default: state_next = S_IDLE;
    endcase

    // Drop a push that would run past the end of the stack.
    stk_we = push && (top < STCW'(DEPTH));
    stk_wa = KAW'(top);
    stk_wd = push_e;
    if (stk_we) top_next = top + STCW'(1);
  end

  always_ff @(posedge clk) begin
    root <= root_next;
    tcnt <= tcnt_next;
    top <= top_next;
    own <= own_next;
    nb <= nb_next;
    pass <= pass_next;
    tl <= tl_next;
    u <= u_next;
    v <= v_next;
    epost <= epost_next;
    earg <= earg_next;
    uinf <= uinf_next;
    if (ov_set) begin
      out_flag <= ov_flag;
      out_status <= ov_status;
    end
    if (rst) begin
      state <= S_INIT;
      idx <= '0;
      slots_used <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx <= idx_next;
      slots_used <= slots_used_next;
      if (ov_set) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

>>> hdl/graph_articulation_point_finder.sv
// Top level: cut vertex finder for an undirected graph, stream ports.
//
// Usage: each input transfer on s_axis carries one command: add an undirected
// edge, run the cut vertex search, or query one node. Every command returns
// exactly one result transfer on m_axis with a status and, for queries, the
// cut flag. cfg_* writes node_count (nodes in use); write it only while idle.
// An edge add links the new slot onto the tail of each endpoint list that is
// not empty. A run first clears the per-node search state, then checks each
// node as a root and follows the stored slots from the search stack; it is
// bound by the single read port of the per-node table and the search stack.
// The front end queues up to two commands ahead of the engine, so commands
// are taken while an earlier result waits on a stalled receiver; the engine
// starts the next command once its result register is free.
// Reset: rst is synchronous. After it, a clearing pass empties the adjacency
// lists and cut flags; s_axis_tready stays low until it ends. Configuration
// writes are taken at any time (cfg_ready is high).
`default_nettype none
module graph_articulation_point_finder
  import gapf_pkg::*;
#(
  parameter int MAX_NODES = DEF_MAX_NODES,
  parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [23:0]      s_axis_tdata,  // operation[1:0], node_a[11:2], node_b[21:12]
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [7:0]            m_axis_tdata,  // is_articulation[0], status[2:1]
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CFG_W-1:0] cfg_data
);

  localparam int CNTW = $clog2(MAX_NODES + 1);
  localparam int KW   = (CNTW > CFG_W) ? CNTW : CFG_W;

  logic [CFG_W-1:0]    node_count;
  logic [CNTW-1:0]     n_eff;
  logic                cmd_valid, cmd_pop, ready_init;
  cmd_t                cmd;
  logic                res_flag;
  logic [STATUS_W-1:0] res_status;

  assign cfg_ready = 1'b1;

  // Hold node_count; reset to 1024 nodes.
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= CFG_W'(1024);
    end else if (cfg_valid && cfg_ready) begin
      node_count <= cfg_data;
    end
  end

  // Clamp the node count to the storage size.
  assign n_eff = (KW'(node_count) < KW'(MAX_NODES)) ? CNTW'(node_count) : CNTW'(MAX_NODES);

  gapf_front #(
    .MAX_NODES(MAX_NODES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_op    (s_axis_tdata[1:0]),
    .in_a     (s_axis_tdata[11:2]),
    .in_b     (s_axis_tdata[21:12]),
    .n_eff    (n_eff),
    .enable   (ready_init),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop)
  );

  gapf_engine #(
    .MAX_NODES(MAX_NODES),
    .MAX_SLOTS(MAX_SLOTS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .n_eff     (n_eff),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .ready_init(ready_init),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_flag  (res_flag),
    .out_status(res_status)
  );

  // Pack the result; upper bits stay zero.
  assign m_axis_tdata = {5'd0, res_status, res_flag};

endmodule
`default_nettype wire
